// ----- design/spom_pkg.sv -----
// shared types and constants for the spiral order matrix reader
package spom_pkg;

  localparam int DEF_MAX_ROWS  = 16;
  localparam int DEF_MAX_COLS  = 16;
  localparam int DEF_WORD_BITS = 32;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int SIZE_W  = 5;
  // room for the largest cell count that two size registers can describe
  localparam int CNT_W   = 2 * SIZE_W;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int OUT_DW  = VALUE_W + 2 * POS_W;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } head_t;

  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_sel_t;

endpackage

// ----- design/spom_front.sv -----
// front end: takes beats, tracks load and spiral positions, issues memory commands
module spom_front #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int WORD_BITS = 32,
  parameter int RW        = 4,
  parameter int CW        = 4,
  parameter int AW        = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic [spom_pkg::SIZE_W-1:0]   size_rows,
  input  logic [spom_pkg::SIZE_W-1:0]   size_cols,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [spom_pkg::VALUE_W-1:0]  in_tdata,
  input  logic                          in_tuser,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output spom_pkg::op_t                 cmd_op,
  output logic [AW-1:0]                 cmd_addr,
  output logic [WORD_BITS-1:0]          cmd_word,
  output logic [RW-1:0]                 cmd_row,
  output logic [CW-1:0]                 cmd_col,
  output logic                          cmd_last
);
  import spom_pkg::*;

  logic [SIZE_W-1:0] eff_rows, eff_cols;
  logic [RW-1:0]     last_row;
  logic [CW-1:0]     last_col;
  logic [CNT_W-1:0]  total;

  logic [RW-1:0] load_row_r, load_row_nxt;
  logic [CW-1:0] load_col_r, load_col_nxt;
  logic [RW-1:0] walk_row_r, walk_row_nxt;
  logic [CW-1:0] walk_col_r, walk_col_nxt;
  logic [RW-1:0] top_r, top_nxt, bot_r, bot_nxt;
  logic [CW-1:0] left_r, left_nxt, right_r, right_nxt;
  head_t         head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic accept, is_fetch, at_last;

  // a size of zero means one, anything beyond the array means the array size
  always_comb begin
    if (size_rows == '0) eff_rows = SIZE_W'(1);
    else if (int'(size_rows) > MAX_ROWS) eff_rows = SIZE_W'(MAX_ROWS);
    else eff_rows = size_rows;
    if (size_cols == '0) eff_cols = SIZE_W'(1);
    else if (int'(size_cols) > MAX_COLS) eff_cols = SIZE_W'(MAX_COLS);
    else eff_cols = size_cols;
  end

  assign last_row = RW'(eff_rows - SIZE_W'(1));
  assign last_col = CW'(eff_cols - SIZE_W'(1));
  assign total    = CNT_W'(eff_rows) * CNT_W'(eff_cols);

  assign in_tready = !cmd_full;
  assign accept    = in_tvalid && !cmd_full;
  assign is_fetch  = (op_t'(in_tuser) == OP_FETCH);
  assign at_last   = (CNT_W'(cnt_r + CNT_W'(1)) >= total);

  // command outputs
  always_comb begin
    cmd_push = accept;
    cmd_op   = op_t'(in_tuser);
    cmd_word = WORD_BITS'(in_tdata);
    cmd_last = at_last;
    if (is_fetch) begin
      cmd_row  = walk_row_r;
      cmd_col  = walk_col_r;
      cmd_addr = AW'(int'(walk_row_r) * MAX_COLS + int'(walk_col_r));
    end else begin
      cmd_row  = load_row_r;
      cmd_col  = load_col_r;
      cmd_addr = AW'(int'(load_row_r) * MAX_COLS + int'(load_col_r));
    end
  end

  // load position, row-major with wrap
  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    if (restart) begin
      load_row_nxt = '0;
      load_col_nxt = '0;
    end else if (accept && !is_fetch) begin
      if (load_col_r == last_col) begin
        load_col_nxt = '0;
        load_row_nxt = (load_row_r == last_row) ? '0 : RW'(load_row_r + RW'(1));
      end else begin
        load_col_nxt = CW'(load_col_r + CW'(1));
      end
    end
  end

  // spiral walk, four shrinking bounds
  always_comb begin
    walk_row_nxt = walk_row_r;
    walk_col_nxt = walk_col_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    if (restart || (accept && is_fetch && at_last)) begin
      walk_row_nxt = '0;
      walk_col_nxt = '0;
      top_nxt      = '0;
      left_nxt     = '0;
      bot_nxt      = last_row;
      right_nxt    = last_col;
      head_nxt     = HEAD_RIGHT;
      cnt_nxt      = '0;
    end else if (accept && is_fetch) begin
      cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
      unique case (head_r)
        HEAD_RIGHT: begin
          if (walk_col_r < right_r) begin
            walk_col_nxt = CW'(walk_col_r + CW'(1));
          end else begin
            top_nxt      = RW'(top_r + RW'(1));
            head_nxt     = HEAD_DOWN;
            walk_row_nxt = RW'(walk_row_r + RW'(1));
          end
        end
        HEAD_DOWN: begin
          if (walk_row_r < bot_r) begin
            walk_row_nxt = RW'(walk_row_r + RW'(1));
          end else begin
            right_nxt    = CW'(right_r - CW'(1));
            head_nxt     = HEAD_LEFT;
            walk_col_nxt = CW'(walk_col_r - CW'(1));
          end
        end
        HEAD_LEFT: begin
          if (walk_col_r > left_r) begin
            walk_col_nxt = CW'(walk_col_r - CW'(1));
          end else begin
            bot_nxt      = RW'(bot_r - RW'(1));
            head_nxt     = HEAD_UP;
            walk_row_nxt = RW'(walk_row_r - RW'(1));
          end
        end
        HEAD_UP: begin
          if (walk_row_r > top_r) begin
            walk_row_nxt = RW'(walk_row_r - RW'(1));
          end else begin
            left_nxt     = CW'(left_r + CW'(1));
            head_nxt     = HEAD_RIGHT;
            walk_col_nxt = CW'(walk_col_r + CW'(1));
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      walk_row_r <= '0;
      walk_col_r <= '0;
      top_r      <= '0;
      left_r     <= '0;
      bot_r      <= '0;
      right_r    <= '0;
      head_r     <= HEAD_RIGHT;
      cnt_r      <= '0;
    end else begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      walk_row_r <= walk_row_nxt;
      walk_col_r <= walk_col_nxt;
      top_r      <= top_nxt;
      left_r     <= left_nxt;
      bot_r      <= bot_nxt;
      right_r    <= right_nxt;
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

// ----- design/spom_queue.sv -----
// two-entry command queue between front and back end
module spom_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         vld,
  output logic [W-1:0] dout
);
  import spom_pkg::*;

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full = (cnt_r == 2'd2);
  assign vld  = (cnt_r != 2'd0);
  assign dout = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = 2'(cnt_r + 2'd1);
    else if (pop && !push) cnt_nxt = 2'(cnt_r - 2'd1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- design/spom_back.sv -----
// back end: cell memory, read stage and output register
module spom_back #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int WORD_BITS = 32,
  parameter int RW        = 4,
  parameter int CW        = 4,
  parameter int AW        = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_vld,
  output logic                         cmd_pop,
  input  spom_pkg::op_t                cmd_op,
  input  logic [AW-1:0]                cmd_addr,
  input  logic [WORD_BITS-1:0]         cmd_word,
  input  logic [RW-1:0]                cmd_row,
  input  logic [CW-1:0]                cmd_col,
  input  logic                         cmd_last,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [spom_pkg::OUT_DW-1:0]  out_tdata,
  output logic                         out_tlast
);
  import spom_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_word_r;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [RW-1:0]        rd_row_r;
  logic [CW-1:0]        rd_col_r;
  logic                 rd_last_r;

  logic                 out_vld_r, out_vld_nxt;
  logic [OUT_DW-1:0]    out_data_r;
  logic                 out_last_r;

  logic advance, rd_free, do_write, do_read;

  assign advance  = rd_vld_r && (!out_vld_r || out_tready);
  assign rd_free  = !rd_vld_r || advance;
  // loads never wait on the output side
  assign cmd_pop  = cmd_vld && ((cmd_op == OP_LOAD) || rd_free);
  assign do_write = cmd_pop && (cmd_op == OP_LOAD);
  assign do_read  = cmd_pop && (cmd_op == OP_FETCH);

  always_comb begin
    rd_vld_nxt = rd_vld_r;
    if (do_read) rd_vld_nxt = 1'b1;
    else if (advance) rd_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (advance) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (do_write) mem[cmd_addr] <= cmd_word;
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_word_r <= mem[cmd_addr];
      rd_row_r  <= cmd_row;
      rd_col_r  <= cmd_col;
      rd_last_r <= cmd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {POS_W'(rd_col_r), POS_W'(rd_row_r), VALUE_W'($signed(rd_word_r))};
      out_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- design/spiral_order_matrix_reader.sv -----
// spiral order matrix reader: top level with size registers and apb port
//
// input channel (in_*): tuser selects the operation, 0 loads tdata into the next cell
// in row-major order, 1 fetches the next cell of the clockwise spiral. a load gives
// no output beat; a fetch gives one beat on out_* carrying the word, its row and
// column, and tlast on the final cell, after which the spiral starts again at the
// top left. the load position wraps after the last cell.
// size registers: num_rows at byte address 0, num_cols at 4, each used as 1 to 16.
// writing either one restarts loading and the spiral at the top left.
// throughput: one beat per cycle in each direction while out_tready stays high;
// front end: one position per beat; cell memory: one write or one read per cycle.
// a fetch passes through a queue slot, the registered memory read and the output
// register before it shows on out_tvalid.
// a stalled receiver fills the output register and read stage, then the two-entry
// queue, then in_tready drops; loads at the queue head still drain, fetches wait.
// reset clears positions and sizes to one by one; the cell memory is not cleared
// and a cell must be loaded before it is fetched.
module spiral_order_matrix_reader #(
  parameter int MAX_ROWS  = spom_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = spom_pkg::DEF_MAX_COLS,
  parameter int WORD_BITS = spom_pkg::DEF_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [spom_pkg::VALUE_W-1:0]  in_tdata,   // value
  input  logic                          in_tuser,   // op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [spom_pkg::OUT_DW-1:0]   out_tdata,  // value_res, row, col
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [spom_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [spom_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [spom_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import spom_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = 1 + AW + WORD_BITS + RW + CW + 1;

  logic [SIZE_W-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic              cfg_wr;
  reg_sel_t          cfg_sel;

  logic          f_push, q_full, q_vld, q_pop;
  op_t           f_op, b_op;
  logic [AW-1:0] f_addr, b_addr;
  logic [WORD_BITS-1:0] f_word, b_word;
  logic [RW-1:0] f_row, b_row;
  logic [CW-1:0] f_col, b_col;
  logic          f_last, b_last;
  logic [QW-1:0] q_din, q_dout;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = reg_sel_t'(cfg_paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      REG_NUM_ROWS: cfg_prdata = CFG_DW'(rows_r);
      REG_NUM_COLS: cfg_prdata = CFG_DW'(cols_r);
    endcase
  end

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_wr) begin
      if (cfg_sel == REG_NUM_ROWS) rows_nxt = cfg_pwdata[SIZE_W-1:0];
      else cols_nxt = cfg_pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_W'(1);
      cols_r <= SIZE_W'(1);
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // the front end sees the size being written, so a restart takes the new bounds
  spom_front #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .WORD_BITS(WORD_BITS),
    .RW(RW), .CW(CW), .AW(AW)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .restart(cfg_wr),
    .size_rows(rows_nxt), .size_cols(cols_nxt),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cmd_full(q_full), .cmd_push(f_push), .cmd_op(f_op), .cmd_addr(f_addr),
    .cmd_word(f_word), .cmd_row(f_row), .cmd_col(f_col), .cmd_last(f_last)
  );

  assign q_din = {f_op, f_addr, f_word, f_row, f_col, f_last};

  spom_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(f_push), .din(q_din), .full(q_full),
    .pop(q_pop), .vld(q_vld), .dout(q_dout)
  );

  always_comb begin
    b_op   = op_t'(q_dout[QW-1]);
    b_addr = q_dout[QW-2 -: AW];
    b_word = q_dout[QW-2-AW -: WORD_BITS];
    b_row  = q_dout[RW+CW : CW+1];
    b_col  = q_dout[CW:1];
    b_last = q_dout[0];
  end

  spom_back #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .WORD_BITS(WORD_BITS),
    .RW(RW), .CW(CW), .AW(AW)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_vld(q_vld), .cmd_pop(q_pop), .cmd_op(b_op),
    .cmd_addr(b_addr), .cmd_word(b_word), .cmd_row(b_row), .cmd_col(b_col),
    .cmd_last(b_last), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule

// ----- design/spom_checker.sv -----
// port-level checks for the spiral order matrix reader, bound to the top level
module spom_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [spom_pkg::OUT_DW-1:0]   out_tdata,
  input logic                          out_tlast
);
  import spom_pkg::*;

  // no result may come out of reset
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat right after reset");

  // queue is empty after reset so input is taken at once
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

endmodule

bind spiral_order_matrix_reader spom_checker u_spom_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
